// File: rtl/tmbt_pkg.sv
package tmbt_pkg;

  localparam int MAX_SEGMENTS_DEFAULT = 64;

  localparam logic [23:0] TEMPO_DEFAULT = 24'd30720;
  localparam logic [23:0] BEAT_DIV = 24'd234375;

  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_ADD   = 3'd1;
  localparam logic [2:0] OP_BUILD = 3'd2;
  localparam logic [2:0] OP_BEAT  = 3'd3;
  localparam logic [2:0] OP_TIME  = 3'd4;
  localparam logic [2:0] OP_TEMPO = 3'd5;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_NOTB  = 2'd2;
  localparam logic [1:0] STAT_SAT   = 2'd3;

endpackage

// File: rtl/tmbt_ram.sv
module tmbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/tempo_map_beat_time_converter.sv
// Channel  Dir  Handshake          Contents
// s        in   s_tvalid/s_tready  one request: op and operands
// m        out  m_tvalid/m_tready  one result per request
//
// A request is taken only in idle; one finished result may wait at the output meanwhile.
// Clear empties the table. An add scans the entries and, unless its time is stored,
// shifts later entries up. A query scans all entries; beat and time queries then use a
// shared multiply and restoring divide unit; build runs it once per segment after the first.
// Reset is synchronous; the table holds one 120 BPM segment at time zero afterwards.
module tempo_map_beat_time_converter #(
  parameter int MAX_SEGMENTS = tmbt_pkg::MAX_SEGMENTS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [151:0] s_tdata,  // change_time, change_tempo, query_time, query_beat
  input  logic [3:0]   s_tuser,  // op, in_steps
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [79:0]  m_tdata,  // result_value, tempo_value, segment_index, zero pad
  output logic [1:0]   m_tuser   // status
);

  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int AW = 51;
  localparam int MW = 24;
  localparam int PW = AW + MW;
  localparam int DW = 27;

  typedef enum logic [4:0] {
    S_IDLE, S_ADD_RD, S_ADD_CMP, S_ADD_DEC, S_SH_RD, S_SH_WR, S_PUT,
    S_B_INIT, S_B_RD0, S_B_CHK, S_B_START, S_B_RD, S_B_NEXT,
    S_Q_RD, S_Q_CMP, S_Q_FRD, S_Q_FETCH, S_MUL, S_DIV, S_FIN, S_DONE
  } state_t;

  state_t state;

  logic [CW-1:0] cnt;
  logic          built;
  logic [IW-1:0] idx;
  logic [IW-1:0] k;
  logic          eq;
  logic          v0tt;
  logic          v0b;
  logic          z0;

  logic [2:0]          op_r;
  logic signed [39:0]  ctime;
  logic [23:0]         ctempo;
  logic signed [39:0]  qtime;
  logic signed [49:0]  b18;
  logic                steps;

  logic signed [39:0]  prev_time;
  logic [23:0]         prev_tempo;
  logic signed [47:0]  prev_beat;
  logic signed [39:0]  cur_time;
  logic [23:0]         cur_tempo;
  logic signed [47:0]  cur_beat;
  logic                sat_acc;

  logic          neg;
  logic [AW-1:0] amag;
  logic [MW-1:0] mreg;
  logic [DW-1:0] dreg;
  logic [PW-1:0] preg;
  logic [DW-1:0] rem;
  logic [4:0]    mc;
  logic [6:0]    dc;

  logic signed [47:0] res_val;
  logic [23:0]        res_tempo;
  logic [IW-1:0]      res_idx;
  logic [1:0]         res_status;

  logic                tt_we;
  logic                b_we;
  logic [IW-1:0]       waddr;
  logic [IW-1:0]       raddr;
  logic signed [39:0]  wtime;
  logic [23:0]         wtempo;
  logic signed [47:0]  wbeat;
  logic [63:0]         tt_q;
  logic [47:0]         b_q;

  logic signed [39:0]  rd_time;
  logic [23:0]         rd_tempo;
  logic signed [47:0]  rd_beat;

  logic                   launch;
  logic signed [AW-1:0]   la_a;
  logic [MW-1:0]          la_m;
  logic [DW-1:0]          la_d;

  logic [48:0]         mag;
  logic                satm;
  logic signed [51:0]  sm;
  logic signed [51:0]  sum;
  logic signed [47:0]  satv;
  logic                sats;
  logic [DW-1:0]       rem_sh;
  logic                hit;
  logic                last;
  logic [31:0]         idx_ext;

  logic signed [39:0]  in_ctime;
  logic [23:0]         in_ctempo;
  logic signed [47:0]  in_qbeat;

  assign in_ctime  = s_tdata[39:0];
  assign in_ctempo = s_tdata[63:40];
  assign in_qbeat  = s_tdata[151:104];

  assign s_tready = (state == S_IDLE);

  tmbt_ram #(.WIDTH(64), .DEPTH(MAX_SEGMENTS)) u_tt_ram (
    .clk  (clk),
    .we   (tt_we),
    .waddr(waddr),
    .wdata({wtempo, wtime}),
    .raddr(raddr),
    .rdata(tt_q)
  );

  tmbt_ram #(.WIDTH(48), .DEPTH(MAX_SEGMENTS)) u_beat_ram (
    .clk  (clk),
    .we   (b_we),
    .waddr(waddr),
    .wdata(wbeat),
    .raddr(raddr),
    .rdata(b_q)
  );

  // Entry zero reads as its reset contents until it is first written.
  assign rd_time  = (z0 && !v0tt) ? 40'sd0 : $signed(tt_q[39:0]);
  assign rd_tempo = (z0 && !v0tt) ? tmbt_pkg::TEMPO_DEFAULT : tt_q[63:40];
  assign rd_beat  = (z0 && !v0b) ? 48'sd0 : $signed(b_q);

  assign last = !((CW'(idx) + CW'(1)) < cnt);
  assign idx_ext = {{(32 - IW){1'b0}}, res_idx};

  always_comb begin
    rem_sh = {rem[DW-2:0], preg[PW-1]};
    if (preg > PW'(49'h1_0000_0000_0000)) begin
      mag  = 49'h1_0000_0000_0000;
      satm = 1'b1;
    end else begin
      mag  = preg[48:0];
      satm = 1'b0;
    end
    sm = neg ? -$signed({3'b000, mag}) : $signed({3'b000, mag});
    case (op_r)
      tmbt_pkg::OP_BUILD: sum = {{4{prev_beat[47]}}, prev_beat} + sm;
      tmbt_pkg::OP_BEAT: begin
        sum = {{4{cur_beat[47]}}, cur_beat} + sm;
        if (steps) begin
          sum = {sum[49:0], 2'b00};
        end
      end
      default: sum = {{12{cur_time[39]}}, cur_time} + sm;
    endcase
    if (sum > 52'sh7FFF_FFFF_FFFF) begin
      satv = 48'sh7FFF_FFFF_FFFF;
      sats = 1'b1;
    end else if (sum < -52'sh8000_0000_0000) begin
      satv = -48'sh8000_0000_0000;
      sats = 1'b1;
    end else begin
      satv = sum[47:0];
      sats = 1'b0;
    end
    if (op_r == tmbt_pkg::OP_TIME) begin
      hit = $signed({rd_beat, 2'b00}) <= b18;
    end else begin
      hit = rd_time <= qtime;
    end
  end

  always_comb begin
    tt_we  = 1'b0;
    b_we   = 1'b0;
    waddr  = k;
    wtime  = ctime;
    wtempo = ctempo;
    wbeat  = satv;
    raddr  = idx;
    launch = 1'b0;
    la_a   = {{11{rd_time[39]}}, rd_time} - {{11{prev_time[39]}}, prev_time};
    la_m   = prev_tempo;
    la_d   = DW'(tmbt_pkg::BEAT_DIV);
    case (state)
      S_ADD_DEC: tt_we = eq;
      S_SH_RD:   raddr = idx - IW'(1);
      S_SH_WR: begin
        tt_we  = 1'b1;
        waddr  = idx;
        wtime  = rd_time;
        wtempo = rd_tempo;
      end
      S_PUT: tt_we = 1'b1;
      S_B_INIT: begin
        tt_we  = 1'b1;
        waddr  = '0;
        wtime  = '0;
        wtempo = tmbt_pkg::TEMPO_DEFAULT;
      end
      S_B_START: begin
        b_we  = 1'b1;
        waddr = '0;
        wbeat = '0;
      end
      S_B_NEXT: launch = (idx != '0);
      S_Q_FETCH: begin
        launch = (op_r != tmbt_pkg::OP_TEMPO);
        if (op_r == tmbt_pkg::OP_TIME) begin
          la_a = {b18[49], b18} - {rd_beat[47], rd_beat, 2'b00};
          la_m = tmbt_pkg::BEAT_DIV;
          la_d = {1'b0, rd_tempo, 2'b00};
        end else begin
          la_a = {{11{qtime[39]}}, qtime} - {{11{rd_time[39]}}, rd_time};
          la_m = rd_tempo;
        end
      end
      S_FIN: begin
        b_we  = (op_r == tmbt_pkg::OP_BUILD);
        waddr = idx;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    z0 <= (raddr == '0);
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= CW'(1);
      built    <= 1'b1;
      v0tt     <= 1'b0;
      v0b      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (tt_we && waddr == '0) begin
        v0tt <= 1'b1;
      end
      if (b_we && waddr == '0) begin
        v0b <= 1'b1;
      end
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      if (launch) begin
        neg   <= la_a[AW-1];
        amag  <= la_a[AW-1] ? AW'(-la_a) : AW'(la_a);
        mreg  <= la_m;
        dreg  <= la_d;
        preg  <= '0;
        mc    <= 5'(MW - 1);
        state <= S_MUL;
        if (state == S_Q_FETCH) begin
          cur_time  <= rd_time;
          cur_tempo <= rd_tempo;
          cur_beat  <= rd_beat;
        end else begin
          cur_time  <= rd_time;
          cur_tempo <= rd_tempo;
        end
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op_r       <= s_tuser[2:0];
            steps      <= s_tuser[3];
            ctime      <= in_ctime;
            ctempo     <= (in_ctempo == '0) ? tmbt_pkg::TEMPO_DEFAULT : in_ctempo;
            qtime      <= s_tdata[103:64];
            b18        <= s_tuser[3] ? {{2{in_qbeat[47]}}, in_qbeat} : {in_qbeat, 2'b00};
            res_val    <= '0;
            res_tempo  <= '0;
            res_idx    <= '0;
            res_status <= tmbt_pkg::STAT_OK;
            idx        <= '0;
            k          <= '0;
            eq         <= 1'b0;
            sat_acc    <= 1'b0;
            case (s_tuser[2:0])
              tmbt_pkg::OP_CLEAR: begin
                cnt   <= '0;
                built <= 1'b0;
                state <= S_DONE;
              end
              tmbt_pkg::OP_ADD:   state <= (cnt == '0) ? S_ADD_DEC : S_ADD_RD;
              tmbt_pkg::OP_BUILD: state <= (cnt == '0) ? S_B_INIT : S_B_RD0;
              tmbt_pkg::OP_BEAT, tmbt_pkg::OP_TIME, tmbt_pkg::OP_TEMPO: begin
                if (!built || cnt == '0) begin
                  res_status <= tmbt_pkg::STAT_NOTB;
                  state      <= S_DONE;
                end else begin
                  state <= S_Q_RD;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_ADD_RD: state <= S_ADD_CMP;
        S_ADD_CMP: begin
          if (rd_time < ctime) begin
            if (!last) begin
              idx   <= idx + IW'(1);
              state <= S_ADD_RD;
            end else begin
              k     <= IW'(cnt);
              state <= S_ADD_DEC;
            end
          end else begin
            k     <= idx;
            eq    <= (rd_time == ctime);
            state <= S_ADD_DEC;
          end
        end
        S_ADD_DEC: begin
          if (eq) begin
            built     <= 1'b0;
            res_tempo <= ctempo;
            res_idx   <= k;
            state     <= S_DONE;
          end else if (cnt >= CW'(MAX_SEGMENTS - 1)) begin
            res_status <= tmbt_pkg::STAT_FULL;
            state      <= S_DONE;
          end else if (cnt > CW'(k)) begin
            idx   <= IW'(cnt);
            state <= S_SH_RD;
          end else begin
            state <= S_PUT;
          end
        end
        S_SH_RD: state <= S_SH_WR;
        S_SH_WR: begin
          if ((idx - IW'(1)) > k) begin
            idx   <= idx - IW'(1);
            state <= S_SH_RD;
          end else begin
            state <= S_PUT;
          end
        end
        S_PUT: begin
          cnt <= cnt + CW'(1);
          if (op_r == tmbt_pkg::OP_BUILD) begin
            state <= S_B_START;
          end else begin
            built     <= 1'b0;
            res_tempo <= ctempo;
            res_idx   <= k;
            state     <= S_DONE;
          end
        end
        S_B_INIT: begin
          cnt   <= CW'(1);
          state <= S_B_START;
        end
        S_B_RD0: state <= S_B_CHK;
        S_B_CHK: begin
          if (rd_time > 40'sd0 && cnt < CW'(MAX_SEGMENTS)) begin
            ctime  <= '0;
            ctempo <= rd_tempo;
            k      <= '0;
            idx    <= IW'(cnt);
            state  <= S_SH_RD;
          end else begin
            state <= S_B_START;
          end
        end
        S_B_START: begin
          idx   <= '0;
          state <= S_B_RD;
        end
        S_B_RD: state <= S_B_NEXT;
        S_B_NEXT: begin
          if (idx == '0) begin
            prev_time  <= rd_time;
            prev_tempo <= rd_tempo;
            prev_beat  <= '0;
            if (!last) begin
              idx   <= idx + IW'(1);
              state <= S_B_RD;
            end else begin
              built   <= 1'b1;
              res_idx <= IW'(cnt - CW'(1));
              state   <= S_DONE;
            end
          end
        end
        S_Q_RD: state <= S_Q_CMP;
        S_Q_CMP: begin
          if (hit) begin
            k <= idx;
          end
          if (!last) begin
            idx   <= idx + IW'(1);
            state <= S_Q_RD;
          end else begin
            idx   <= hit ? idx : k;
            state <= S_Q_FRD;
          end
        end
        S_Q_FRD: state <= S_Q_FETCH;
        S_Q_FETCH: begin
          res_tempo <= rd_tempo;
          res_idx   <= k;
          if (op_r == tmbt_pkg::OP_TEMPO) begin
            state <= S_DONE;
          end
        end
        S_MUL: begin
          preg <= {preg[PW-2:0], 1'b0} + (mreg[mc] ? PW'(amag) : PW'(0));
          if (mc == '0) begin
            rem   <= '0;
            dc    <= 7'(PW - 1);
            state <= S_DIV;
          end else begin
            mc <= mc - 5'd1;
          end
        end
        S_DIV: begin
          if (rem_sh >= dreg) begin
            rem  <= rem_sh - dreg;
            preg <= {preg[PW-2:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            preg <= {preg[PW-2:0], 1'b0};
          end
          if (dc == '0) begin
            state <= S_FIN;
          end else begin
            dc <= dc - 7'd1;
          end
        end
        S_FIN: begin
          if (op_r == tmbt_pkg::OP_BUILD) begin
            prev_time  <= cur_time;
            prev_tempo <= cur_tempo;
            prev_beat  <= satv;
            if (!last) begin
              sat_acc <= sat_acc | satm | sats;
              idx     <= idx + IW'(1);
              state   <= S_B_RD;
            end else begin
              built      <= 1'b1;
              res_idx    <= IW'(cnt - CW'(1));
              res_status <= (sat_acc || satm || sats) ? tmbt_pkg::STAT_SAT
                                                      : tmbt_pkg::STAT_OK;
              state      <= S_DONE;
            end
          end else begin
            res_val    <= satv;
            res_status <= (satm || sats) ? tmbt_pkg::STAT_SAT : tmbt_pkg::STAT_OK;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            idx      <= res_idx;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {2'b00, idx_ext[5:0], res_tempo, res_val};
      m_tuser <= res_status;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser[2:0] == tmbt_pkg::OP_CLEAR) |=> (cnt == '0 && !built))
    else $error("clear did not empty the table");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && res_status == tmbt_pkg::STAT_FULL)
      |-> (cnt >= CW'(MAX_SEGMENTS - 1)))
    else $error("add refused while the table had room");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL || state == S_DIV) |-> (dreg != '0))
    else $error("divide started with a zero divisor");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !m_tvalid) |=> (m_tvalid && state == S_IDLE))
    else $error("finished result was not presented");

endmodule
